// File: design/divisor_sum_abundance_test_unit_macros.svh
// Assertion macros shared by the divisor-sum abundance test unit.
`ifndef DIVISOR_SUM_ABUNDANCE_TEST_UNIT_MACROS_SVH
`define DIVISOR_SUM_ABUNDANCE_TEST_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define DSAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DSAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DSAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DSAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/dsat_pkg.sv
// Shared types and constants of the divisor-sum abundance test unit.
package dsat_pkg;

    localparam int SUM_W = 23;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic open_factor;
        logic take_factor;
        logic mul_step;
        logic add_term;
        logic close_factor;
        logic next_div;
        logic final_mul;
        logic final_add;
        logic finish;
    } dsat_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic quo_lt_div;
        logic rem_zero;
        logic mul_done;
        logic rest_gt1;
    } dsat_status_t;

endpackage

// File: design/divisor_sum_abundance_test_unit.sv
// Top level of the divisor-sum abundance test unit.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-----------------------------------
//  input    | start && !busy         | number
//  result   | done (one-cycle pulse) | proper_divisor_sum, is_abundant
//
// Each candidate divisor makes one pass through the one-bit-per-cycle divider; candidates
// are 2 and then odd values up to the square root of the cofactor. Each prime power found
// adds one more division and a shift-add multiply; a leftover prime adds a final multiply.
// Reset clears the controller; the result pulse comes in the cycle after the final state,
// with busy already low. No stall exists.
module divisor_sum_abundance_test_unit
    import dsat_pkg::*;
#(
    parameter int NUMBER_WIDTH = 20
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUMBER_WIDTH-1:0] number,
    output logic                    busy,
    output logic                    done,
    output logic [SUM_W-1:0]        proper_divisor_sum,
    output logic                    is_abundant
);

    dsat_cmd_t    cmd;
    dsat_status_t status;

    dsat_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    dsat_datapath #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .number             (number),
        .cmd                (cmd),
        .status             (status),
        .proper_divisor_sum (proper_divisor_sum),
        .is_abundant        (is_abundant)
    );

endmodule

// File: design/dsat_datapath.sv
// Datapath: shared restoring divider, shift-add multiplier and sigma registers.
module dsat_datapath
    import dsat_pkg::*;
#(
    parameter int NUMBER_WIDTH = 20
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [NUMBER_WIDTH-1:0] number,
    input  dsat_cmd_t               cmd,
    output dsat_status_t            status,
    output logic [SUM_W-1:0]        proper_divisor_sum,
    output logic                    is_abundant
);

    localparam int N_W     = NUMBER_WIDTH;
    localparam int D_W     = NUMBER_WIDTH / 2 + 2;
    localparam int SIGMA_W = NUMBER_WIDTH + 3;
    localparam int CNT_W   = $clog2(NUMBER_WIDTH + 1);
    localparam int CMP_W   = (SIGMA_W > SUM_W) ? SIGMA_W : SUM_W;

    logic [N_W-1:0]     n_reg;
    logic [N_W-1:0]     rest_reg;
    logic [D_W-1:0]     d_reg;
    logic [SIGMA_W-1:0] sigma_reg;
    logic [SIGMA_W-1:0] acc_reg;
    logic [SIGMA_W-1:0] term_reg;
    logic [D_W-1:0]     rem_reg;
    logic [N_W-1:0]     quo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SIGMA_W-1:0] mul_a_reg;
    logic [N_W-1:0]     mul_b_reg;
    logic [SIGMA_W-1:0] prod_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               abundant_reg;

    logic [D_W:0]       partial;
    logic               div_ge;
    logic [D_W:0]       partial_diff;
    logic [SIGMA_W-1:0] proper;
    logic [CMP_W-1:0]   proper_ext;
    logic               sat;
    logic [SUM_W-1:0]   sum_next;
    logic               abundant_next;

    // One quotient bit per cycle: shift the next dividend bit into the remainder.
    assign partial      = {rem_reg, quo_reg[N_W-1]};
    assign div_ge       = partial >= {1'b0, d_reg};
    assign partial_diff = partial - {1'b0, d_reg};

    // sigma always includes the number itself, so this never wraps for a nonzero number.
    assign proper     = sigma_reg - SIGMA_W'(n_reg);
    assign proper_ext = CMP_W'(proper);
    assign sat        = proper_ext > CMP_W'(SUM_MAX);

    always_comb
    begin
        if (n_reg == '0)
        begin
            sum_next      = '0;
            abundant_next = 1'b0;
        end
        else
        begin
            sum_next      = sat ? SUM_MAX : proper_ext[SUM_W-1:0];
            abundant_next = proper > SIGMA_W'(n_reg);
        end
    end

    assign status.div_done   = (cnt_reg == '0);
    assign status.quo_lt_div = quo_reg < N_W'(d_reg);
    assign status.rem_zero   = (rem_reg == '0);
    assign status.mul_done   = (mul_b_reg == '0);
    assign status.rest_gt1   = rest_reg > N_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            cnt_reg <= CNT_W'(N_W);
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg     <= number;
            rest_reg  <= number;
            d_reg     <= D_W'(2);
            sigma_reg <= SIGMA_W'(1);
        end

        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= rest_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? partial_diff[D_W-1:0] : partial[D_W-1:0];
            quo_reg <= {quo_reg[N_W-2:0], div_ge};
        end

        if (cmd.take_factor)
        begin
            rest_reg  <= quo_reg;
            mul_a_reg <= cmd.open_factor ? sigma_reg : term_reg;
            mul_b_reg <= N_W'(d_reg);
            prod_reg  <= '0;
            if (cmd.open_factor)
            begin
                acc_reg <= sigma_reg;
            end
        end
        else if (cmd.final_mul)
        begin
            mul_a_reg <= sigma_reg;
            mul_b_reg <= rest_reg;
            prod_reg  <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (mul_b_reg[0])
            begin
                prod_reg <= prod_reg + mul_a_reg;
            end
            mul_a_reg <= {mul_a_reg[SIGMA_W-2:0], 1'b0};
            mul_b_reg <= {1'b0, mul_b_reg[N_W-1:1]};
        end

        // Each new power of the prime adds sigma_before * p^k to the running sum.
        if (cmd.add_term)
        begin
            term_reg <= prod_reg;
            acc_reg  <= acc_reg + prod_reg;
        end

        if (cmd.close_factor)
        begin
            sigma_reg <= acc_reg;
        end
        else if (cmd.final_add)
        begin
            sigma_reg <= sigma_reg + prod_reg;
        end

        // Only odd candidates after two; composites never divide what is left.
        if (cmd.next_div)
        begin
            d_reg <= (d_reg == D_W'(2)) ? D_W'(3) : d_reg + D_W'(2);
        end

        if (cmd.finish)
        begin
            sum_reg      <= sum_next;
            abundant_reg <= abundant_next;
        end
    end

    assign proper_divisor_sum = sum_reg;
    assign is_abundant        = abundant_reg;

endmodule

// File: design/dsat_ctrl.sv
// Controller state machine sequencing trial division and sigma updates.
`include "divisor_sum_abundance_test_unit_macros.svh"
module dsat_ctrl
    import dsat_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  dsat_status_t status,
    output dsat_cmd_t    cmd,
    output logic         busy,
    output logic         done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_INIT,
        S_DIV,
        S_EVAL,
        S_MUL,
        S_LEFT,
        S_FMUL,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_factor_reg;
    logic   in_factor_next;
    logic   done_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        in_factor_next = in_factor_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load       = 1'b1;
                    in_factor_next = 1'b0;
                    state_next     = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_EVAL:
            begin
                if (in_factor_reg)
                begin
                    if (status.rem_zero)
                    begin
                        cmd.take_factor = 1'b1;
                        state_next      = S_MUL;
                    end
                    else
                    begin
                        cmd.close_factor = 1'b1;
                        cmd.next_div     = 1'b1;
                        in_factor_next   = 1'b0;
                        state_next       = S_DIV_INIT;
                    end
                end
                // A quotient below the divisor means divisor squared exceeds the cofactor.
                else if (status.quo_lt_div)
                begin
                    state_next = S_LEFT;
                end
                else if (status.rem_zero)
                begin
                    cmd.open_factor = 1'b1;
                    cmd.take_factor = 1'b1;
                    in_factor_next  = 1'b1;
                    state_next      = S_MUL;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    state_next   = S_DIV_INIT;
                end
            end
            S_MUL:
            begin
                if (status.mul_done)
                begin
                    cmd.add_term = 1'b1;
                    state_next   = S_DIV_INIT;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            S_LEFT:
            begin
                if (status.rest_gt1)
                begin
                    cmd.final_mul = 1'b1;
                    state_next    = S_FMUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FMUL:
            begin
                if (status.mul_done)
                begin
                    cmd.final_add = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_factor_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_factor_reg <= in_factor_next;
            done_reg      <= cmd.finish;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    `DSAT_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `DSAT_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `DSAT_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `DSAT_ASSERT_IMP(a_unit_excl, clk, rst_n, cmd.div_step, !cmd.mul_step)

endmodule

// File: sim/divisor_sum_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the proper divisor sum and abundance flag of each item and compares results.
module divisor_sum_checker
    import dsat_pkg::*;
#(
    parameter int NUMBER_WIDTH = 20
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUMBER_WIDTH-1:0] number,
    input  logic                    busy,
    input  logic                    done,
    input  logic [SUM_W-1:0]        proper_divisor_sum,
    input  logic                    is_abundant,
    output int                      fail_count,
    output int                      pending_count,
    output int                      result_count,
    output int                      abundant_count
);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             abundant;
    } aliquot_t;

    aliquot_t aliquot_queue[$];
    int       failures = 0;
    int       waiting = 0;
    int       results = 0;
    int       abundants = 0;

    assign fail_count     = failures;
    assign pending_count  = waiting;
    assign result_count   = results;
    assign abundant_count = abundants;

    // Factor by trial division and form sigma as the product of the prime power series.
    function automatic aliquot_t aliquot_of(input logic [NUMBER_WIDTH-1:0] n);
        longint unsigned rest;
        longint unsigned d;
        longint unsigned sigma;
        longint unsigned series;
        longint unsigned power;
        longint unsigned proper;
        aliquot_t        r;
        r = '0;
        if (n == 0)
        begin
            return r;
        end
        rest  = n;
        sigma = 1;
        d     = 2;
        while (d * d <= rest)
        begin
            if (rest % d == 0)
            begin
                series = 1;
                power  = 1;
                while (rest % d == 0)
                begin
                    rest   = rest / d;
                    power  = power * d;
                    series = series + power;
                end
                sigma = sigma * series;
            end
            d++;
        end
        // Whatever is left above one is a single prime.
        if (rest > 1)
        begin
            sigma = sigma * (rest + 1);
        end
        proper     = sigma - n;
        r.sum      = (proper > SUM_MAX) ? SUM_MAX : proper[SUM_W-1:0];
        r.abundant = (proper > n);
        return r;
    endfunction

    task automatic note_failure(input string what);
        failures++;
        if (failures <= 10)
        begin
            $display("%0t ns: MISMATCH %s", $time, what);
        end
    endtask

    always @(posedge clk)
    begin
        aliquot_t want;
        if (rst_n)
        begin
            // A result and a new item can meet at one edge; retire the result first.
            if (done)
            begin
                if (aliquot_queue.size() == 0)
                begin
                    note_failure($sformatf("result with no item waiting: sum %0d abundant %0b",
                                           proper_divisor_sum, is_abundant));
                end
                else
                begin
                    want = aliquot_queue.pop_front();
                    results++;
                    if (is_abundant === 1'b1)
                    begin
                        abundants++;
                    end
                    if (proper_divisor_sum !== want.sum)
                    begin
                        note_failure($sformatf("proper_divisor_sum: expected %0d, got %0d",
                                               want.sum, proper_divisor_sum));
                    end
                    if (is_abundant !== want.abundant)
                    begin
                        note_failure($sformatf("is_abundant: expected %0b, got %0b",
                                               want.abundant, is_abundant));
                    end
                end
            end
            if (start && !busy)
            begin
                aliquot_queue = {aliquot_queue, aliquot_of(number)};
            end
            waiting = aliquot_queue.size();
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Top of the divisor-sum abundance test unit regression: clock, reset, stimulus and verdict.
module tb;
    import dsat_pkg::*;

    localparam int              NUMBER_WIDTH = 20;
    localparam longint unsigned NUMBER_SPAN  = 64'd1 << NUMBER_WIDTH;
    localparam int              CYCLE_LIMIT  = 8_000_000;
    localparam int              RANDOM_ITEMS = 117;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic [NUMBER_WIDTH-1:0] number;
    logic                    busy;
    logic                    done;
    logic [SUM_W-1:0]        proper_divisor_sum;
    logic                    is_abundant;

    int fail_count;
    int pending_count;
    int result_count;
    int abundant_count;
    int cycles = 0;
    int sent = 0;

    // Zero and one, perfect numbers, the first even and odd abundant numbers, squares
    // near the top, a large prime cofactor, bit patterns and the extremes.
    int unsigned directed_numbers[23] = '{
        0, 1, 2, 3, 4, 6, 9, 12, 28, 945, 1024, 30030, 720720, 999983,
        1042441, 1046529, 524288, 1048574, 1048575, 349525, 699050, 0, 1
    };
    int unsigned small_primes[10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
    int unsigned big_primes[5]    = '{101, 997, 1009, 4093, 65521};

    divisor_sum_abundance_test_unit #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .number             (number),
        .busy               (busy),
        .done               (done),
        .proper_divisor_sum (proper_divisor_sum),
        .is_abundant        (is_abundant)
    );

    divisor_sum_checker #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) checker_inst (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .number             (number),
        .busy               (busy),
        .done               (done),
        .proper_divisor_sum (proper_divisor_sum),
        .is_abundant        (is_abundant),
        .fail_count         (fail_count),
        .pending_count      (pending_count),
        .result_count       (result_count),
        .abundant_count     (abundant_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d items outstanding.",
                     pending_count);
            $display("divisor_sum_abundance_test_unit regression: fail");
            $finish;
        end
    end

    // Hold the item until the unit takes it; an idle gap may come first, counted from
    // the point where the unit could take the item.
    task automatic send_number(input logic [NUMBER_WIDTH-1:0] n, input bit may_idle);
        @(negedge clk);
        if (may_idle && $urandom_range(0, 99) < 33)
        begin
            start <= 1'b0;
            while (busy)
            begin
                @(negedge clk);
            end
            // Mostly short gaps, now and then a long one.
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(20, 2000)
                                                : $urandom_range(1, 12))
            begin
                @(negedge clk);
            end
        end
        start  <= 1'b1;
        number <= n;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        longint unsigned n;
        longint unsigned p;
        int              pick;
        rst_n  = 1'b0;
        start  = 1'b0;
        number = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_numbers[i])
        begin
            send_number(directed_numbers[i][NUMBER_WIDTH-1:0], 1'b1);
        end
        wait_drained();

        // Small numbers dominate to keep the trial division short; products of
        // prime powers exercise the factor loop, and a few span the full width.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 40)
            begin
                n = 64'($urandom_range(1, 4095));
            end
            else if (pick < 60)
            begin
                n = 64'($urandom_range(1, 65535));
            end
            else if (pick < 70)
            begin
                n = 64'($urandom_range(0, 32'(NUMBER_SPAN - 1)));
            end
            else
            begin
                n = 1;
                repeat ($urandom_range(1, 5))
                begin
                    p = 64'(small_primes[$urandom_range(0, 9)]);
                    repeat ($urandom_range(1, 4))
                    begin
                        if (n * p < NUMBER_SPAN)
                        begin
                            n = n * p;
                        end
                    end
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    p = 64'(big_primes[$urandom_range(0, 4)]);
                    if (n * p < NUMBER_SPAN)
                    begin
                        n = n * p;
                    end
                end
            end
            if (i == 100)
            begin
                wait_drained();
            end
            send_number(n[NUMBER_WIDTH-1:0], (i < 50) || (i >= 90));
        end

        wait_drained();
        repeat (50) @(negedge clk);

        $display("Sent %0d numbers (%0d directed); %0d results checked, %0d of them abundant.",
                 sent, $size(directed_numbers), result_count, abundant_count);
        $display("Covered zero, one, primes, prime squares, perfect and abundant numbers, %s",
                 "prime power products and full-width values.");
        if (fail_count == 0)
        begin
            $display("divisor_sum_abundance_test_unit regression: pass");
        end
        else
        begin
            $display("divisor_sum_abundance_test_unit regression: fail");
        end
        $finish;
    end

endmodule

// File: divisor_sum_abundance_test_unit.f
+incdir+design
design/dsat_pkg.sv
design/dsat_datapath.sv
design/dsat_ctrl.sv
design/divisor_sum_abundance_test_unit.sv
sim/divisor_sum_checker.sv
sim/tb.sv
